FILE: rtl/ptd_pkg.sv
// Shared types and codes for the periodic task dispatcher.
`default_nettype none
package ptd_pkg;
  localparam int NUM_SLOTS = 16;

  localparam logic [1:0] FUNC_ADD  = 2'd0;
  localparam logic [1:0] FUNC_TICK = 2'd1;
  localparam logic [1:0] FUNC_DONE = 2'd2;

  localparam logic [1:0] KIND_ADD  = 2'd0;
  localparam logic [1:0] KIND_DISP = 2'd1;
  localparam logic [1:0] KIND_NEXT = 2'd2;
  localparam logic [1:0] KIND_STAT = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_NOIDX = 2'd2;

  typedef struct packed {
    logic [31:0] period;
    logic [31:0] last_start;
    logic [7:0]  rank;
    logic [31:0] deadline;
    logic [31:0] run_total;
    logic [31:0] time_total;
    logic [31:0] time_peak;
    logic [31:0] miss_total;
  } entry_t;
endpackage
`default_nettype wire

FILE: rtl/periodic_task_dispatcher_core.sv
// Top level of the periodic task dispatcher: sequencer around one task table memory.
//
// Sequence: add searches the ranks, then shifts entries from the top slot down to the
//   insert slot (a full table gets status full straight from idle); tick reads each entry
//   and writes it back if due; completion reads the indexed entry and writes it back.
// Throughput: one item at a time; busy drops in the cycle of the final result, so the
//   next transfer can land there.
// Results are strobed by valid for one cycle; the receiver cannot stall.
// Reset: rst (synchronous, active high) clears task_count and the sequencer;
//   table entries are undefined until written.
`default_nettype none
module periodic_task_dispatcher_core
  import ptd_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  output logic        busy,
  input  wire  [1:0]  func,
  input  wire  [31:0] now_ms,
  input  wire  [31:0] period_ms,
  input  wire  [7:0]  priority_req,
  input  wire  [3:0]  task_index,
  input  wire  [31:0] duration_ms,
  output logic        valid,
  output logic [1:0]  kind,
  output logic [1:0]  status,
  output logic [3:0]  slot,
  output logic [31:0] due_in_ms,
  output logic [31:0] runs,
  output logic [31:0] busy_total_ms,
  output logic [31:0] longest_ms,
  output logic [31:0] overruns,
  output logic        overran,
  output logic        last
);
  localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_SRCH  = 8'b00000010,  // add: scan ranks for insert position
    S_SHIFT = 8'b00000100,  // add: move entries up one slot
    S_TRD   = 8'b00001000,  // tick: read data arriving, write back if due
    S_TWR   = 8'b00010000,  // tick: issue next read, or finish after the last entry
    S_CRD   = 8'b00100000,  // completion: read data arriving
    S_CWR   = 8'b01000000,
    S_DONE  = 8'b10000000
  } state_t;

  state_t state;
  logic [CW-1:0] task_count;
  logic [CW-1:0] ptr;
  logic [AW-1:0] pos;
  logic [31:0]   now_q, ivl_q, dur_q, next_min;
  logic [7:0]    prio_q;
  logic [3:0]    idx_q;

  // Table memory: one read and one write port, registered read data.
  entry_t mem [NUM_SLOTS];
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  entry_t        rd_data, wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  // Rank search uses a compact rank copy so the insert point is found in one pass.
  logic [7:0] rank_shadow [NUM_SLOTS];

  logic [31:0] elapsed, remain;
  logic        due;
  logic        idx_ok;
  entry_t      upd;
  logic        late;
  assign elapsed = now_q - rd_data.last_start;
  assign due     = (elapsed >= rd_data.period);
  assign remain  = rd_data.period - elapsed;
  assign late    = now_q > rd_data.deadline;
  assign idx_ok  = ({{(32-4){1'b0}}, idx_q} < 32'(task_count));

  always_comb begin
    upd = rd_data;
    upd.run_total  = rd_data.run_total + 32'd1;
    upd.time_total = rd_data.time_total + dur_q;
    if (dur_q > rd_data.time_peak) upd.time_peak = dur_q;
    if (late) upd.miss_total = rd_data.miss_total + 32'd1;
  end

  always_comb begin
    rd_addr = ptr[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = ptr[AW-1:0];
    wr_data = rd_data;
    unique case (state)
      S_IDLE: begin
        // issue the first read so its data lands in the first busy cycle
        rd_addr = (func == FUNC_DONE) ? task_index[AW-1:0] : '0;
      end
      S_SRCH: begin
        // prefetch the top entry for the first shift
        rd_addr = AW'(task_count - CW'(1));
      end
      S_SHIFT: begin
        // hold read of ptr-1 in rd_data; write at ptr
        rd_addr = AW'(ptr - CW'(2));
        wr_en   = 1'b1;
        if (ptr[AW-1:0] == pos) begin
          wr_data = '{period: ivl_q, last_start: now_q, rank: prio_q, deadline: 32'd0,
                      run_total: 32'd0, time_total: 32'd0, time_peak: 32'd0,
                      miss_total: 32'd0};
        end
      end
      S_TRD: begin
        wr_en = due;
        wr_data.deadline   = rd_data.last_start + rd_data.period;
        wr_data.last_start = now_q;
        rd_addr = AW'(ptr + CW'(1));
      end
      S_CRD: begin
        rd_addr = idx_q[AW-1:0];
        wr_addr = idx_q[AW-1:0];
        wr_en   = idx_ok;
        wr_data = upd;
      end
      default: ;
    endcase
  end

  // Insert position: first slot whose rank exceeds the request.
  logic [AW-1:0] ins_pos;
  always_comb begin
    ins_pos = AW'(task_count);
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (CW'(i) < task_count && rank_shadow[i] > prio_q) ins_pos = AW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SHIFT) begin
      if (ptr[AW-1:0] == pos) rank_shadow[ptr[AW-1:0]] <= prio_q;
      else rank_shadow[ptr[AW-1:0]] <= rank_shadow[AW'(ptr - CW'(1))];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      task_count <= '0;
      valid      <= 1'b0;
      last       <= 1'b0;
      ptr        <= '0;
    end else begin
      valid <= 1'b0;
      last  <= 1'b0;
      kind <= KIND_ADD; status <= ST_OK; slot <= '0; due_in_ms <= '0;
      runs <= '0; busy_total_ms <= '0; longest_ms <= '0; overruns <= '0; overran <= 1'b0;
      unique case (state)
        S_IDLE: if (start) begin
          now_q <= now_ms; ivl_q <= period_ms; prio_q <= priority_req;
          idx_q <= task_index; dur_q <= duration_ms;
          next_min <= '1;
          ptr <= '0;
          unique case (func)
            FUNC_ADD: begin
              if (task_count == CW'(NUM_SLOTS)) begin
                valid <= 1'b1; last <= 1'b1; status <= ST_FULL;
              end else state <= S_SRCH;
            end
            FUNC_TICK: begin
              if (task_count == '0) begin
                valid <= 1'b1; last <= 1'b1; kind <= KIND_NEXT; due_in_ms <= '1;
              end else state <= S_TRD;
            end
            FUNC_DONE: state <= S_CRD;
            default: ;
          endcase
        end
        S_SRCH: begin
          // pos fixed; shift from top slot down to pos, reading slot below
          pos   <= ins_pos;
          ptr   <= task_count;
          state <= S_SHIFT;
        end
        S_SHIFT: begin
          // write at ptr uses rd_data (slot ptr-1) latched prior cycle
          if (ptr[AW-1:0] == pos) begin
            task_count <= task_count + CW'(1);
            valid <= 1'b1; last <= 1'b1; slot <= 4'(pos);
            state <= S_IDLE;
          end else ptr <= ptr - CW'(1);
        end
        S_TRD: begin
          if (due) begin
            valid <= 1'b1; kind <= KIND_DISP; slot <= 4'(ptr);
          end else if (remain < next_min) next_min <= remain;
          ptr   <= ptr + CW'(1);
          state <= S_TWR;
        end
        S_TWR: begin
          if (ptr == task_count) begin
            valid <= 1'b1; last <= 1'b1; kind <= KIND_NEXT; due_in_ms <= next_min;
            state <= S_IDLE;
          end else state <= S_TRD;
        end
        S_CRD: begin
          valid <= 1'b1; last <= 1'b1; kind <= KIND_STAT; slot <= idx_q;
          if (idx_ok) begin
            runs <= upd.run_total; busy_total_ms <= upd.time_total;
            longest_ms <= upd.time_peak; overruns <= upd.miss_total; overran <= late;
          end else status <= ST_NOIDX;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

  // Idle issues the read for the entry the next item starts on: the completion index,
  // or slot 0 for a tick. Add prefetches the top entry during the search cycle.

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    task_count <= CW'(NUM_SLOTS)) else $error("task count overflow");
  a_last_valid: assert property (@(posedge clk) disable iff (rst)
    last |-> valid) else $error("last without valid");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (valid && last) |-> !busy) else $error("final result while busy");
endmodule
`default_nettype wire
